>>> src/udff_pkg.sv
package udff_pkg;

  localparam int unsigned VALUE_BITS_DEF  = 32;
  localparam int unsigned FIELD_LIMIT_DEF = 63;

  localparam int unsigned CNT_W     = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 6;
  localparam int unsigned CHAR_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_PRECISION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRECISION_GIVEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ALIGN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD        = 3'd4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // double-dabble digit correction
  function automatic logic [3:0] bcd_adjust(input logic [3:0] dig);
    return (dig >= 4'd5) ? dig + 4'd3 : dig;
  endfunction

endpackage

>>> src/unsigned_decimal_field_formatter.sv
// From input transfer to the first character, D the digit count (1 to 10), the steps are:
// 32 shift-and-add-3 steps (VALUE_BITS), 10 - D leading-zero drops, trim end, field setup, load.
// A field without digits (zero value, precision 0 given) skips the drops and the trim end.
// Throughput: one character per cycle while the output is not stalled; the next value is taken
// once the last character of a field is loaded.
// Reset: configuration registers clear to zero, sequencer idle, no character pending.
module unsigned_decimal_field_formatter
  import udff_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned FIELD_LIMIT = FIELD_LIMIT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic [CNT_W-1:0]      char_count_o,
  output logic                  last_char_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int unsigned MAX_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W      = MAX_DIGITS * 4;
  localparam int unsigned DIG_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BIT_W      = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(FIELD_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SETUP,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       width_q, prec_q;
  logic                   prec_given_q, left_q, zpad_q;
  logic [VALUE_BITS-1:0]  bin_q;
  logic [BCD_W-1:0]       bcd_q;
  logic [BIT_W-1:0]       bit_cnt_q;
  logic [DIG_W-1:0]       ndig_q;
  logic                   empty_q;
  logic [CNT_W-1:0]       npad_q, nzero_q, total_q, count_q;
  logic                   zfill_q;
  logic                   out_valid_q, last_q;
  logic [CHAR_W-1:0]      char_q;
  logic [CNT_W-1:0]       cnt_out_q;

  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       ndig_ext, nzero_c, content_c, npad_c, total_c;
  logic                   in_xfer, out_free;
  logic [CNT_W-1:0]       cfg_sat;

  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      bcd_adj[d*4 +: 4] = bcd_adjust(bcd_q[d*4 +: 4]);
    end
  end

  always_comb begin
    ndig_ext  = CNT_W'(ndig_q);
    nzero_c   = (prec_given_q && (prec_q > ndig_ext)) ? prec_q - ndig_ext : '0;
    content_c = ndig_ext + nzero_c;
    npad_c    = (width_q > content_c) ? width_q - content_c : '0;
    total_c   = (width_q > content_c) ? width_q : content_c;
    if (total_c > LIMIT) begin
      total_c = LIMIT;
    end
  end

  assign cfg_sat     = (cfg_data_i > LIMIT) ? LIMIT : cfg_data_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      width_q      <= '0;
      prec_q       <= '0;
      prec_given_q <= 1'b0;
      left_q       <= 1'b0;
      zpad_q       <= 1'b0;
      bin_q        <= '0;
      bcd_q        <= '0;
      bit_cnt_q    <= '0;
      ndig_q       <= '0;
      empty_q      <= 1'b0;
      npad_q       <= '0;
      nzero_q      <= '0;
      total_q      <= '0;
      count_q      <= '0;
      zfill_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      last_q       <= 1'b0;
      char_q       <= '0;
      cnt_out_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_FIELD_WIDTH:     width_q      <= cfg_sat;
          CFG_DIGIT_PRECISION: prec_q       <= cfg_sat;
          CFG_PRECISION_GIVEN: prec_given_q <= cfg_data_i[0];
          CFG_LEFT_ALIGN:      left_q       <= cfg_data_i[0];
          CFG_ZERO_PAD:        zpad_q       <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_free) begin
        out_valid_q <= (state_q == ST_EMIT);
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            bin_q     <= value_i;
            bcd_q     <= '0;
            bit_cnt_q <= BIT_W'(VALUE_BITS - 1);
            empty_q   <= (value_i == '0) && prec_given_q && (prec_q == '0);
            state_q   <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
          bin_q <= bin_q << 1;
          if (bit_cnt_q == '0) begin
            ndig_q  <= empty_q ? '0 : DIG_W'(MAX_DIGITS);
            state_q <= empty_q ? ST_SETUP : ST_NORM;
          end else begin
            bit_cnt_q <= bit_cnt_q - 1'b1;
          end
        end
        ST_NORM: begin
          // drop leading zero digits, keep at least one
          if ((ndig_q > DIG_W'(1)) && (bcd_q[BCD_W-1 -: 4] == 4'd0)) begin
            bcd_q  <= bcd_q << 4;
            ndig_q <= ndig_q - 1'b1;
          end else begin
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          nzero_q <= nzero_c;
          npad_q  <= npad_c;
          total_q <= total_c;
          count_q <= '0;
          zfill_q <= zpad_q && !left_q && !prec_given_q;
          state_q <= (total_c == '0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            cnt_out_q   <= count_q + 1'b1;
            last_q      <= (count_q + 1'b1) == total_q;
            count_q     <= count_q + 1'b1;
            if ((count_q + 1'b1) == total_q) begin
              state_q <= ST_IDLE;
            end
            priority if (!left_q && (npad_q != '0)) begin
              char_q <= zfill_q ? CH_ZERO : CH_SPACE;
              npad_q <= npad_q - 1'b1;
            end else if (nzero_q != '0) begin
              char_q  <= CH_ZERO;
              nzero_q <= nzero_q - 1'b1;
            end else if (ndig_q != '0) begin
              char_q <= CH_ZERO | {4'd0, bcd_q[BCD_W-1 -: 4]};
              bcd_q  <= bcd_q << 4;
              ndig_q <= ndig_q - 1'b1;
            end else begin
              char_q <= CH_SPACE;
              npad_q <= npad_q - 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = char_q;
  assign char_count_o = cnt_out_q;
  assign last_char_o  = last_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("formatter not busy after input transfer");

  a_next_char_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_char_o |=> out_valid_o)
    else $error("gap inside a field");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_char_o |=>
      char_count_o == $past(char_count_o) + 1'b1)
    else $error("character count did not advance");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_count_o != '0) && (char_count_o <= LIMIT))
    else $error("character count out of range");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import udff_pkg::*;

  localparam int unsigned VALUE_W      = VALUE_BITS_DEF;
  localparam int unsigned RADIX        = 10;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_VALUES = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_ZERO_PAD + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = {CFG_IDX_W{1'b1}};
  localparam logic [CFG_DAT_W-1:0] WIDTH_MAX    = CFG_DAT_W'(FIELD_LIMIT_DEF);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [CNT_W-1:0]  count;
    logic              last;
  } glyph_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [VALUE_W-1:0]   value_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [CHAR_W-1:0]    out_char_o;
  logic [CNT_W-1:0]     char_count_o;
  logic                 last_char_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i   = '0;

  logic [VALUE_W-1:0] pending_values [$];
  glyph_t             expected_glyphs [$];

  logic [CNT_W-1:0] fmt_width;
  logic [CNT_W-1:0] fmt_precision;
  logic             fmt_prec_given;
  logic             fmt_left_align;
  logic             fmt_zero_pad;

  bit calm;
  int unsigned mismatches;
  int unsigned values_sent;
  int unsigned glyphs_checked;
  int unsigned settings_used;
  int unsigned quiet_cycles;

  unsigned_decimal_field_formatter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .char_count_o (char_count_o),
    .last_char_o  (last_char_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom() >> $urandom_range(0, VALUE_W - 1);
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_size(input int unsigned typical_max);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return WIDTH_MAX;
      default: return CNT_W'($urandom_range(1, typical_max));
    endcase
  endfunction

  // printf %u: digits, leading zeros to the precision, then padding to the width, cut at FIELD_LIMIT_DEF
  function automatic void queue_field(input logic [VALUE_W-1:0] v);
    logic [CHAR_W-1:0]  text [$];
    logic [VALUE_W-1:0] rest;
    int unsigned        n_dig;
    int unsigned        n_pad;
    int unsigned        total;
    bit                 fill0;
    glyph_t             g;
    rest  = v;
    fill0 = fmt_zero_pad && !fmt_left_align && !fmt_prec_given;
    if (!(v == 0 && fmt_prec_given && fmt_precision == 0)) begin
      do begin
        text.push_front(CH_ZERO + CHAR_W'(rest % RADIX));
        rest = rest / RADIX;
      end while (rest != 0);
    end
    n_dig = text.size();
    if (fmt_prec_given && fmt_precision > n_dig)
      repeat (fmt_precision - n_dig) text.push_front(CH_ZERO);
    n_pad = (fmt_width > text.size()) ? fmt_width - text.size() : 0;
    repeat (n_pad) begin
      if (fmt_left_align) text.push_back(CH_SPACE);
      else text.push_front(fill0 ? CH_ZERO : CH_SPACE);
    end
    total = (text.size() > FIELD_LIMIT_DEF) ? FIELD_LIMIT_DEF : text.size();
    for (int unsigned i = 0; i < total; i++) begin
      g.ch    = text[i];
      g.count = CNT_W'(i + 1);
      g.last  = (i + 1 == total);
      expected_glyphs.push_back(g);
    end
  endfunction

  // value sender
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      in_gap     = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        queue_field(value_i);
        values_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (pending_values.size() > 0) begin
          in_valid_i <= 1'b1;
          value_i    <= pending_values.pop_front();
          in_gap     = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // character receiver and checker
  int unsigned out_hold;
  always @(posedge clk_i or negedge rst_ni) begin
    glyph_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold    = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        glyphs_checked++;
        if (expected_glyphs.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected character %h count %0d last %b", $realtime,
                     out_char_o, char_count_o, last_char_o);
        end else begin
          want = expected_glyphs.pop_front();
          if (out_char_o !== want.ch || char_count_o !== want.count ||
              last_char_o !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] char %h/%h count %0d/%0d last %b/%b (expected/actual)",
                       $realtime, want.ch, out_char_o, want.count, char_count_o,
                       want.last, last_char_o);
          end
        end
      end
      if (out_hold == 0) out_hold = pick_gap();
      out_stall_i <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d characters outstanding",
               quiet_cycles, expected_glyphs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FIELD_WIDTH:     fmt_width      = data;
      CFG_DIGIT_PRECISION: fmt_precision  = data;
      CFG_PRECISION_GIVEN: fmt_prec_given = data[0];
      CFG_LEFT_ALIGN:      fmt_left_align = data[0];
      CFG_ZERO_PAD:        fmt_zero_pad   = data[0];
      default: ;
    endcase
  endtask

  // flag registers get random upper bits, which must be ignored
  task automatic apply_format(input logic [CNT_W-1:0] width, input logic [CNT_W-1:0] prec,
                              input bit prec_given, input bit left, input bit zpad);
    logic [CFG_DAT_W-1:0] junk;
    junk = CFG_DAT_W'($urandom) & ~CFG_DAT_W'(1);
    write_reg(CFG_FIELD_WIDTH, width);
    write_reg(CFG_DIGIT_PRECISION, prec);
    write_reg(CFG_PRECISION_GIVEN, junk | prec_given);
    write_reg(CFG_LEFT_ALIGN, junk | left);
    write_reg(CFG_ZERO_PAD, junk | zpad);
    if ($urandom_range(0, 1))
      write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                CFG_DAT_W'($urandom));
    settings_used++;
    calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic settle();
    while (pending_values.size() > 0 || in_valid_i || expected_glyphs.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    fmt_width      = '0;
    fmt_precision  = '0;
    fmt_prec_given = 1'b0;
    fmt_left_align = 1'b0;
    fmt_zero_pad   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset format: plain digits
    pending_values = '{0, 1, 9, 10, 1000000000, 32'hFFFF_FFFF};
    settle();

    // widest field, zero padded
    apply_format(WIDTH_MAX, '0, 1'b0, 1'b0, 1'b1);
    pending_values = '{0, 32'hFFFF_FFFF, 42};
    settle();

    // zero value with zero precision: nothing at all, then with a width
    apply_format('0, '0, 1'b1, 1'b0, 1'b0);
    pending_values = '{0, 7, 0};
    settle();
    apply_format(CNT_W'(4), '0, 1'b1, 1'b1, 1'b0);
    pending_values = '{0, 5};
    settle();

    // widest precision
    apply_format('0, WIDTH_MAX, 1'b1, 1'b0, 1'b0);
    pending_values = '{0, 32'hFFFF_FFFF};
    settle();

    // zero padding overridden by precision, then by left alignment
    apply_format(CNT_W'(12), CNT_W'(5), 1'b1, 1'b0, 1'b1);
    pending_values = '{123, 4294967};
    settle();
    apply_format(CNT_W'(20), '0, 1'b0, 1'b1, 1'b1);
    pending_values = '{0, 32'hFFFF_FFFF, 31415};
    settle();

    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      apply_format(pick_size(24), pick_size(12), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1));
      repeat (PHASE_VALUES) pending_values.push_back(pick_value());
      settle();
    end

    $display("Formatted %0d values under %0d register settings, %0d characters checked.",
             values_sent, settings_used, glyphs_checked);
    if (mismatches == 0)
      $display("TEST PASSED");
    else begin
      $display("%0d character mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
